// File: sv/bacc_pkg.sv
// ----------------------------------------------------------------------------
// bacc_pkg
// Shared types and constants of the block access consistency checker.
// ----------------------------------------------------------------------------
package bacc_pkg;

  localparam int unsigned WorkerIdBitsDefault = 10;
  localparam int unsigned SectionBitsDefault  = 16;

  typedef enum logic [1:0] {
    ACT_GET   = 2'd0,
    ACT_PUT   = 2'd1,
    ACT_ACC   = 2'd2,
    ACT_OTHER = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_READ    = 3'd1,
    MODE_WRITE   = 3'd2,
    MODE_ACCUM   = 3'd3,
    MODE_SINGLE  = 3'd4,
    MODE_INVALID = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_OPEN    = 2'd0,
    KIND_ONE     = 2'd1,
    KIND_MANY    = 2'd2,
    KIND_INVALID = 2'd3
  } kind_e;

  // per-request status handed from the tracker to the result stage
  typedef struct packed {
    logic  consistent;
    logic  fatal_reset;
    mode_e mode;
    kind_e kind;
  } res_status_t;

endpackage

// File: sv/bacc_in_stage.sv
// ----------------------------------------------------------------------------
// bacc_in_stage
// Input register of the checker: captures one request per cycle while in_stall_o is low.
// ----------------------------------------------------------------------------
module bacc_in_stage #(
  parameter int unsigned WORKER_ID_BITS = bacc_pkg::WorkerIdBitsDefault,
  parameter int unsigned SECTION_BITS   = bacc_pkg::SectionBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [WORKER_ID_BITS-1:0] worker_id_i,
  input  logic [SECTION_BITS-1:0]   section_number_i,
  input  logic                      advance_i,
  output logic                      req_valid_o,
  output bacc_pkg::action_e         req_action_o,
  output logic [WORKER_ID_BITS-1:0] req_worker_o,
  output logic [SECTION_BITS-1:0]   req_section_o
);
  import bacc_pkg::*;

  logic                      valid_q;
  action_e                   action_q;
  logic [WORKER_ID_BITS-1:0] worker_q;
  logic [SECTION_BITS-1:0]   section_q;
  logic                      load;

  // the register is free when empty or when its request moves on this cycle
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      action_q  <= action_e'(action_i);
      worker_q  <= worker_id_i;
      section_q <= section_number_i;
    end
  end

  assign req_valid_o   = valid_q;
  assign req_action_o  = action_q;
  assign req_worker_o  = worker_q;
  assign req_section_o = section_q;

endmodule

// File: sv/bacc_tracker.sv
// ----------------------------------------------------------------------------
// bacc_tracker
// Block state (mode, owner, last section) and the per-request transition.
// ----------------------------------------------------------------------------
module bacc_tracker #(
  parameter int unsigned WORKER_ID_BITS = bacc_pkg::WorkerIdBitsDefault,
  parameter int unsigned SECTION_BITS   = bacc_pkg::SectionBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  bacc_pkg::action_e         req_action_i,
  input  logic [WORKER_ID_BITS-1:0] req_worker_i,
  input  logic [SECTION_BITS-1:0]   req_section_i,
  output bacc_pkg::res_status_t     status_o,
  output logic [WORKER_ID_BITS-1:0] owner_o
);
  import bacc_pkg::*;

  mode_e                     mode_q, mode_d;
  kind_e                     kind_q, kind_d;
  logic [WORKER_ID_BITS-1:0] id_q, id_d;
  logic [SECTION_BITS-1:0]   section_q, section_d;

  logic                      newer;
  logic                      invalid;
  mode_e                     mode_cur;
  kind_e                     kind_cur;
  logic [WORKER_ID_BITS-1:0] id_cur;
  mode_e                     mode_n;
  kind_e                     kind_n;
  logic [WORKER_ID_BITS-1:0] id_n;
  logic                      ok;
  logic                      one;
  logic                      many;
  logic                      same;

  assign newer   = req_section_i > section_q;
  assign invalid = (mode_q == MODE_INVALID) || (kind_q == KIND_INVALID);

  // a newer section reopens a healthy block before the access is checked
  always_comb begin
    if (newer) begin
      mode_cur = MODE_NONE;
      kind_cur = KIND_OPEN;
      id_cur   = '0;
    end else begin
      mode_cur = mode_q;
      kind_cur = kind_q;
      id_cur   = id_q;
    end
  end

  assign one  = kind_cur == KIND_ONE;
  assign many = kind_cur == KIND_MANY;
  assign same = one && (id_cur == req_worker_i);

  always_comb begin
    ok     = 1'b0;
    mode_n = mode_cur;
    kind_n = kind_cur;
    id_n   = id_cur;
    unique case (mode_cur)
      MODE_NONE: begin
        if (kind_cur == KIND_OPEN && req_action_i != ACT_OTHER) begin
          ok     = 1'b1;
          kind_n = KIND_ONE;
          id_n   = req_worker_i;
          unique case (req_action_i)
            ACT_GET: mode_n = MODE_READ;
            ACT_PUT: mode_n = MODE_WRITE;
            default: mode_n = MODE_ACCUM;
          endcase
        end
      end
      MODE_READ: begin
        if (many) begin
          if (req_action_i == ACT_GET) begin
            ok = 1'b1;
          end
        end else if (one) begin
          if (req_action_i == ACT_GET) begin
            ok = 1'b1;
            if (!same) begin
              kind_n = KIND_MANY;
              id_n   = '0;
            end
          end else if (req_action_i != ACT_OTHER && same) begin
            ok     = 1'b1;
            mode_n = MODE_SINGLE;
          end
        end
      end
      MODE_WRITE, MODE_SINGLE: begin
        if (same) begin
          ok     = 1'b1;
          mode_n = MODE_SINGLE;
        end
      end
      MODE_ACCUM: begin
        if (many) begin
          if (req_action_i == ACT_ACC) begin
            ok = 1'b1;
          end
        end else if (one) begin
          if (req_action_i == ACT_ACC) begin
            ok = 1'b1;
            if (!same) begin
              kind_n = KIND_MANY;
              id_n   = '0;
            end
          end else if (req_action_i != ACT_OTHER && same) begin
            ok     = 1'b1;
            mode_n = MODE_SINGLE;
          end
        end
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      mode_n = MODE_INVALID;
      kind_n = KIND_INVALID;
      id_n   = '0;
    end
  end

  // an invalid block is sticky; only the section counter keeps moving
  always_comb begin
    section_d = newer ? req_section_i : section_q;
    if (invalid) begin
      mode_d = mode_q;
      kind_d = kind_q;
      id_d   = id_q;
    end else begin
      mode_d = mode_n;
      kind_d = kind_n;
      id_d   = id_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NONE;
      kind_q    <= KIND_OPEN;
      id_q      <= '0;
      section_q <= '0;
    end else if (advance_i) begin
      mode_q    <= mode_d;
      kind_q    <= kind_d;
      id_q      <= id_d;
      section_q <= section_d;
    end
  end

  assign status_o.consistent  = !invalid && ok;
  assign status_o.fatal_reset = invalid && newer;
  assign status_o.mode        = mode_d;
  assign status_o.kind        = kind_d;
  assign owner_o              = (kind_d == KIND_ONE) ? id_d : '0;

endmodule

// File: sv/bacc_out_stage.sv
// ----------------------------------------------------------------------------
// bacc_out_stage
// Result register of the checker, holds a result until it is taken.
// ----------------------------------------------------------------------------
module bacc_out_stage #(
  parameter int unsigned WORKER_ID_BITS = bacc_pkg::WorkerIdBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  bacc_pkg::res_status_t     status_i,
  input  logic [WORKER_ID_BITS-1:0] owner_i,
  output logic                      advance_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      consistent_o,
  output logic                      fatal_reset_o,
  output logic [2:0]                block_mode_o,
  output logic [1:0]                owner_kind_o,
  output logic [WORKER_ID_BITS-1:0] owner_worker_o
);
  import bacc_pkg::*;

  logic                      valid_q;
  res_status_t               status_q;
  logic [WORKER_ID_BITS-1:0] owner_q;

  assign advance_o = req_valid_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      status_q <= status_i;
      owner_q  <= owner_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign consistent_o   = status_q.consistent;
  assign fatal_reset_o  = status_q.fatal_reset;
  assign block_mode_o   = status_q.mode;
  assign owner_kind_o   = status_q.kind;
  assign owner_worker_o = owner_q;

endmodule

// File: sv/block_access_consistency_checker.sv
// ----------------------------------------------------------------------------
// block_access_consistency_checker
// Access consistency tracking for one shared data block.
// ----------------------------------------------------------------------------
// Each request carries an action, a worker id and a barrier section number and
// yields exactly one result with the consistency verdict and the block's mode
// and owner after the access. A request passes an input register, is checked
// against the block state and lands in a result register, so one request is
// taken per cycle while the output is not stalled, and its result is offered
// from the result register. A conflict makes the block invalid until reset; a
// newer section arriving then raises fatal_reset.
module block_access_consistency_checker #(
  parameter int unsigned WORKER_ID_BITS = bacc_pkg::WorkerIdBitsDefault,
  parameter int unsigned SECTION_BITS   = bacc_pkg::SectionBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [WORKER_ID_BITS-1:0] worker_id_i,
  input  logic [SECTION_BITS-1:0]   section_number_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      consistent_o,
  output logic                      fatal_reset_o,
  output logic [2:0]                block_mode_o,
  output logic [1:0]                owner_kind_o,
  output logic [WORKER_ID_BITS-1:0] owner_worker_o
);
  import bacc_pkg::*;

  logic                      advance;
  logic                      req_valid;
  action_e                   req_action;
  logic [WORKER_ID_BITS-1:0] req_worker;
  logic [SECTION_BITS-1:0]   req_section;
  res_status_t               status;
  logic [WORKER_ID_BITS-1:0] owner;

  bacc_in_stage #(
    .WORKER_ID_BITS (WORKER_ID_BITS),
    .SECTION_BITS   (SECTION_BITS)
  ) u_in_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .worker_id_i      (worker_id_i),
    .section_number_i (section_number_i),
    .advance_i        (advance),
    .req_valid_o      (req_valid),
    .req_action_o     (req_action),
    .req_worker_o     (req_worker),
    .req_section_o    (req_section)
  );

  bacc_tracker #(
    .WORKER_ID_BITS (WORKER_ID_BITS),
    .SECTION_BITS   (SECTION_BITS)
  ) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .req_action_i  (req_action),
    .req_worker_i  (req_worker),
    .req_section_i (req_section),
    .status_o      (status),
    .owner_o       (owner)
  );

  bacc_out_stage #(
    .WORKER_ID_BITS (WORKER_ID_BITS)
  ) u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .status_i       (status),
    .owner_i        (owner),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .consistent_o   (consistent_o),
    .fatal_reset_o  (fatal_reset_o),
    .block_mode_o   (block_mode_o),
    .owner_kind_o   (owner_kind_o),
    .owner_worker_o (owner_worker_o)
  );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the block access consistency checker. It predicts
// the mode and owner of the shared block for every accepted request and
// compares each result, field by field, in order. The block is driven with
// directed accesses, then with random well-formed access sequences over
// growing barrier sections, and last with a conflict that makes the block
// invalid, followed by the fatal cases that newer sections cause.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bacc_pkg::*;

  localparam int unsigned WID     = 10;
  localparam int unsigned SECW    = 16;
  localparam int          SEC_TOP = 60000;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 10;

  typedef struct {
    bit               consistent;
    bit               fatal;
    mode_e            mode;
    kind_e            kind;
    logic [WID-1:0]   owner;
  } verdict_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic [1:0]      action = '0;
  logic [WID-1:0]  worker_id = '0;
  logic [SECW-1:0] section = '0;
  logic            out_stall = 1'b0;

  logic            in_stall;
  logic            out_valid;
  logic            consistent;
  logic            fatal_reset;
  logic [2:0]      block_mode;
  logic [1:0]      owner_kind;
  logic [WID-1:0]  owner_worker;

  // predicted block state
  mode_e           blk_mode = MODE_NONE;
  kind_e           blk_kind = KIND_OPEN;
  logic [WID-1:0]  blk_owner = '0;
  logic [SECW-1:0] blk_section = '0;

  verdict_t        expected_verdicts[$];
  int              errors = 0;
  int              quiet_cycles = 0;
  int              epochs_left = 150;
  int              send_idle_pct = 24;
  int              recv_idle_pct = 46;

  block_access_consistency_checker #(
    .WORKER_ID_BITS(WID),
    .SECTION_BITS  (SECW)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .worker_id_i     (worker_id),
    .section_number_i(section),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .consistent_o    (consistent),
    .fatal_reset_o   (fatal_reset),
    .block_mode_o    (block_mode),
    .owner_kind_o    (owner_kind),
    .owner_worker_o  (owner_worker)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void set_block(mode_e m, kind_e k, logic [WID-1:0] id);
    blk_mode  = m;
    blk_kind  = k;
    blk_owner = (k == KIND_ONE) ? id : '0;
  endfunction

  // mode table for a block that is still valid
  function automatic bit grant_access(action_e act, logic [WID-1:0] w);
    bit one;
    bit many;
    bit same;
    one  = (blk_kind == KIND_ONE);
    many = (blk_kind == KIND_MANY);
    same = one && (blk_owner == w);
    case (blk_mode)
      MODE_NONE: begin
        if (blk_kind != KIND_OPEN) return 1'b0;
        case (act)
          ACT_GET: set_block(MODE_READ, KIND_ONE, w);
          ACT_PUT: set_block(MODE_WRITE, KIND_ONE, w);
          ACT_ACC: set_block(MODE_ACCUM, KIND_ONE, w);
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      MODE_READ: begin
        if (many) begin
          if (act != ACT_GET) return 1'b0;
          set_block(MODE_READ, KIND_MANY, '0);
          return 1'b1;
        end
        if (!one) return 1'b0;
        if (act == ACT_GET) begin
          if (same) set_block(MODE_READ, KIND_ONE, w);
          else set_block(MODE_READ, KIND_MANY, '0);
          return 1'b1;
        end
        if ((act == ACT_PUT || act == ACT_ACC) && same) begin
          set_block(MODE_SINGLE, KIND_ONE, w);
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_WRITE, MODE_SINGLE: begin
        if (!same) return 1'b0;
        set_block(MODE_SINGLE, KIND_ONE, w);
        return 1'b1;
      end
      MODE_ACCUM: begin
        if (many) begin
          if (act != ACT_ACC) return 1'b0;
          set_block(MODE_ACCUM, KIND_MANY, '0);
          return 1'b1;
        end
        if (!one) return 1'b0;
        if (act == ACT_GET || act == ACT_PUT) begin
          if (!same) return 1'b0;
          set_block(MODE_SINGLE, KIND_ONE, w);
          return 1'b1;
        end
        if (act == ACT_ACC) begin
          if (same) set_block(MODE_ACCUM, KIND_ONE, w);
          else set_block(MODE_ACCUM, KIND_MANY, '0);
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit advance_block(input action_e act, input logic [WID-1:0] w,
                                       input logic [SECW-1:0] sec, output bit fatal);
    bit was_invalid;
    bit ok;
    was_invalid = (blk_mode == MODE_INVALID) || (blk_kind == KIND_INVALID);
    fatal = 1'b0;
    ok = 1'b0;
    if (sec > blk_section) begin
      blk_section = sec;
      if (was_invalid) fatal = 1'b1;
      else set_block(MODE_NONE, KIND_OPEN, '0);
    end
    if (!was_invalid) begin
      ok = grant_access(act, w);
      if (!ok) set_block(MODE_INVALID, KIND_INVALID, '0);
    end
    return ok;
  endfunction

  // trial run on a copy of the state, used to build well-formed sequences
  function automatic bit access_ok(action_e act, logic [WID-1:0] w, logic [SECW-1:0] sec);
    mode_e           m;
    kind_e           k;
    logic [WID-1:0]  o;
    logic [SECW-1:0] s;
    bit              f;
    bit              ok;
    m = blk_mode;
    k = blk_kind;
    o = blk_owner;
    s = blk_section;
    ok = advance_block(act, w, sec, f);
    blk_mode = m;
    blk_kind = k;
    blk_owner = o;
    blk_section = s;
    return ok;
  endfunction

  function automatic void track_access(action_e act, logic [WID-1:0] w, logic [SECW-1:0] sec);
    verdict_t v;
    v.consistent = advance_block(act, w, sec, v.fatal);
    v.mode  = blk_mode;
    v.kind  = blk_kind;
    v.owner = (blk_kind == KIND_ONE) ? blk_owner : '0;
    expected_verdicts.push_back(v);
  endfunction

  function automatic bit block_invalid();
    return (blk_mode == MODE_INVALID) || (blk_kind == KIND_INVALID);
  endfunction

  // newer section, spread so that the run climbs through the whole range
  function automatic logic [SECW-1:0] fresh_section();
    int span;
    span = (int'(blk_section) >= SEC_TOP) ? 0 :
           2 * (SEC_TOP - int'(blk_section)) / (epochs_left + 1);
    if (epochs_left > 1) epochs_left--;
    return SECW'(int'(blk_section) + 1 + $urandom_range(span));
  endfunction

  function automatic logic [WID-1:0] pick_worker();
    logic [WID-1:0] crew [4] = '{10'h000, 10'h3ff, 10'h155, 10'h2aa};
    int r;
    r = $urandom_range(9);
    if (r < 4 && blk_kind == KIND_ONE) return blk_owner;
    if (r < 9) return crew[$urandom_range(3)];
    return WID'($urandom_range((1 << WID) - 1));
  endfunction

  // ------------------------------------------------------------ drive / check

  task automatic send_access(input action_e act, input logic [WID-1:0] w,
                             input logic [SECW-1:0] sec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    worker_id <= w;
    section   <= sec;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_access(act, w, sec);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      flag_error($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        flag_error("result with no request pending");
      end else begin
        want = expected_verdicts.pop_front();
        check_field("consistent", 16'(consistent), 16'(want.consistent));
        check_field("fatal_reset", 16'(fatal_reset), 16'(want.fatal));
        check_field("block_mode", 16'(block_mode), 16'(want.mode));
        check_field("owner_kind", 16'(owner_kind), 16'(want.kind));
        check_field("owner_worker", 16'(owner_worker), 16'(want.owner));
      end
    end
  end

  // ends the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog expired");
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_directed_modes();
    send_access(ACT_GET,   10'h000, 16'd0);  // section 0 is not newer than reset
    send_access(ACT_GET,   10'h3ff, 16'd0);  // second reader makes it shared
    send_access(ACT_GET,   10'h005, 16'd0);
    send_access(ACT_PUT,   10'h007, 16'd1);  // newer section clears the block
    send_access(ACT_OTHER, 10'h007, 16'd1);  // other type by the writer is fine
    send_access(ACT_GET,   10'h007, 16'd0);  // older section keeps the state
    send_access(ACT_ACC,   10'h3ff, 16'd2);
    send_access(ACT_ACC,   10'h3ff, 16'd2);
    send_access(ACT_ACC,   10'h003, 16'd2);  // second accumulator
    send_access(ACT_ACC,   10'h000, 16'd1);
    send_access(ACT_ACC,   10'h200, 16'd3);
    send_access(ACT_GET,   10'h200, 16'd3);
    send_access(ACT_PUT,   10'h200, 16'd3);
    send_access(ACT_OTHER, 10'h200, 16'd3);
    send_access(ACT_GET,   10'h155, 16'd4);
    send_access(ACT_ACC,   10'h155, 16'd4);  // reader upgrades to single worker
    send_access(ACT_GET,   10'h2aa, 16'd5);
    send_access(ACT_PUT,   10'h2aa, 16'd5);
    send_access(ACT_ACC,   10'h064, 16'd6);
    send_access(ACT_PUT,   10'h064, 16'd6);
    send_access(ACT_PUT,   10'h3ff, 16'd7);
    drain_results();
  endtask

  // random accesses that never conflict, so the block stays valid
  task automatic test_random_accesses(input int count);
    action_e         act;
    logic [WID-1:0]  w;
    logic [SECW-1:0] sec;
    bit              found;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) == 0) drain_results();
      if ($urandom_range(99) < 25) sec = fresh_section();
      else if ($urandom_range(3) == 0) sec = SECW'($urandom_range(int'(blk_section)));
      else sec = blk_section;
      found = 1'b0;
      act = ACT_GET;
      w = '0;
      for (int t = 0; t < 30 && !found; t++) begin
        act = action_e'($urandom_range(3));
        w = pick_worker();
        found = access_ok(act, w, sec);
      end
      if (!found) begin
        act = ACT_GET;
        sec = fresh_section();
      end
      send_access(act, w, sec);
    end
    drain_results();
  endtask

  task automatic test_conflict_and_fatal();
    action_e        act;
    logic [WID-1:0] w;
    int             tries;
    send_access(ACT_GET, pick_worker(), fresh_section());
    tries = 0;
    while (!block_invalid() && tries < 50) begin
      act = action_e'($urandom_range(3));
      w = pick_worker();
      send_access(act, w, blk_section);
      tries++;
    end
    // other type on a freshly cleared block is always a conflict
    if (!block_invalid()) send_access(ACT_OTHER, pick_worker(), fresh_section());
    send_access(ACT_GET, 10'h155, blk_section);
    send_access(ACT_PUT, 10'h2aa, blk_section - 1'b1);
    send_access(ACT_ACC, 10'h155, blk_section + 1'b1);  // newer while invalid
    repeat (20) begin
      act = action_e'($urandom_range(3));
      send_access(act, WID'($urandom_range((1 << WID) - 1)), SECW'($urandom_range(65534)));
    end
    send_access(ACT_OTHER, 10'h3ff, 16'hffff);
    send_access(ACT_GET, 10'h000, 16'hffff);
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_modes();
    test_random_accesses(170);

    send_idle_pct = 46;
    recv_idle_pct = 24;
    test_random_accesses(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_accesses(170);

    test_conflict_and_fatal();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_verdicts.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_verdicts.size()));
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
